FILE: hw/rtl/pfbrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbrf_pkg
// Shared constants for the paged monochrome frame store with rectangle fill.
// ----------------------------------------------------------------------------
package pfbrf_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;

  localparam int unsigned PAGE_ROWS   = 8;
  localparam int unsigned PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int unsigned PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [PAGE_W-1:0] page_t;

endpackage

FILE: hw/rtl/page_framebuffer_rect_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_rect_fill
// Paged 1-bit-per-pixel frame store with clear, rectangle fill and byte read.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. After reset the store is
// swept to zero, all STORE_BYTES (1024) bytes, before the first request is
// taken. A clear rewrites every byte of the store, a fill reads and rewrites
// each byte of the touched pages within the clipped columns, a read fetches
// one byte, and a request that changes nothing goes straight to its result.
// The single RAM port pair sets the pace: each page byte costs one read and
// one write, overlapped so that one byte retires per cycle. The result
// register frees the input as soon as a result is parked, so a new request
// may be taken while it waits.
// ----------------------------------------------------------------------------
module page_framebuffer_rect_fill
  import pfbrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic       color_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic       off_screen_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam logic [8:0] SCR_W9 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] SCR_H9 = 9'(SCREEN_HEIGHT);

  logic [2:0] state_q, state_d;
  addr_t      clr_cnt_q, clr_cnt_d;
  addr_t      page_base_q, page_base_d;
  col_t       col_q, col_d;
  col_t       first_col_q, first_col_d;
  col_t       last_col_q, last_col_d;
  page_t      page_q, page_d;
  page_t      first_page_q, first_page_d;
  page_t      last_page_q, last_page_d;
  logic [2:0] first_row_q, first_row_d;
  logic [2:0] last_row_q, last_row_d;
  logic       color_q, color_d;
  logic       res_rd_q, res_rd_d;
  logic       res_off_q, res_off_d;
  logic       wr_pend_q, wr_pend_d;
  addr_t      wr_addr_q, wr_addr_d;
  logic [7:0] wr_mask_q, wr_mask_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] read_byte_q, read_byte_d;
  logic       off_screen_q, off_screen_d;

  logic       accept;
  logic       on_screen;
  logic [8:0] x_sum, y_sum, col_lim, row_lim, last_col9, last_row9;
  page_t      in_page;
  addr_t      in_base;
  addr_t      cur_addr;
  logic [2:0] mask_lo, mask_hi;
  logic [7:0] cur_mask;
  logic       out_free;

  logic       ram_we, ram_re;
  addr_t      ram_waddr;
  logic [7:0] ram_wdata, ram_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign on_screen = ({1'b0, x_pos_i} < SCR_W9) && ({1'b0, y_pos_i} < SCR_H9);
  assign x_sum     = {1'b0, x_pos_i} + {1'b0, rect_width_i};
  assign y_sum     = {1'b0, y_pos_i} + {1'b0, rect_height_i};
  assign col_lim   = (x_sum > SCR_W9) ? SCR_W9 : x_sum;
  assign row_lim   = (y_sum > SCR_H9) ? SCR_H9 : y_sum;
  assign last_col9 = col_lim - 9'd1;
  assign last_row9 = row_lim - 9'd1;
  assign in_page   = PAGE_W'(y_pos_i >> 3);
  assign in_base   = ADDR_W'(in_page * SCREEN_WIDTH);

  assign cur_addr = page_base_q + ADDR_W'(col_q);
  assign mask_lo  = (page_q == first_page_q) ? first_row_q : 3'd0;
  assign mask_hi  = (page_q == last_page_q) ? last_row_q : 3'd7;
  assign cur_mask = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    page_base_d  = page_base_q;
    col_d        = col_q;
    first_col_d  = first_col_q;
    last_col_d   = last_col_q;
    page_d       = page_q;
    first_page_d = first_page_q;
    last_page_d  = last_page_q;
    first_row_d  = first_row_q;
    last_row_d   = last_row_q;
    color_d      = color_q;
    res_rd_d     = res_rd_q;
    res_off_d    = res_off_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = wr_addr_q;
    wr_mask_d    = wr_mask_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    read_byte_d  = read_byte_q;
    off_screen_d = off_screen_q;
    ram_re       = 1'b0;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
          clr_cnt_d = '0;
          state_d   = (state_q == ST_INIT) ? ST_IDLE : ST_FINISH;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_rd_d     = 1'b0;
          res_off_d    = 1'b0;
          color_d      = color_i;
          page_base_d  = in_base;
          col_d        = COL_W'(x_pos_i);
          first_col_d  = COL_W'(x_pos_i);
          last_col_d   = COL_W'(last_col9);
          page_d       = in_page;
          first_page_d = in_page;
          last_page_d  = PAGE_W'(last_row9 >> 3);
          first_row_d  = y_pos_i[2:0];
          last_row_d   = last_row9[2:0];
          clr_cnt_d    = '0;
          unique case (kind_i)
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_FILL: begin
              res_off_d = !on_screen;
              if (on_screen && (rect_width_i != 8'd0) && (rect_height_i != 8'd0)) begin
                state_d = ST_FILL;
              end else begin
                state_d = ST_FINISH;
              end
            end
            KIND_READ: begin
              res_off_d = !on_screen;
              res_rd_d  = on_screen;
              state_d   = on_screen ? ST_READ : ST_FINISH;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_FILL: begin
        ram_re    = 1'b1;
        wr_pend_d = 1'b1;
        wr_addr_d = cur_addr;
        wr_mask_d = cur_mask;
        col_d     = col_q + COL_W'(1);
        if (col_q == last_col_q) begin
          col_d = first_col_q;
          if (page_q == last_page_q) begin
            state_d = ST_FINISH;
          end else begin
            page_d      = page_q + PAGE_W'(1);
            page_base_d = page_base_q + ADDR_W'(SCREEN_WIDTH);
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          read_byte_d  = res_rd_q ? ram_rdata : 8'd0;
          off_screen_d = res_off_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = color_q ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q);
    end else begin
      ram_we    = (state_q == ST_INIT) || (state_q == ST_CLEAR);
      ram_waddr = clr_cnt_q;
      ram_wdata = 8'd0;
    end
  end

  pfbrf_ram #(
    .Width(8),
    .Depth(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cur_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_base_q  <= page_base_d;
    col_q        <= col_d;
    first_col_q  <= first_col_d;
    last_col_q   <= last_col_d;
    page_q       <= page_d;
    first_page_q <= first_page_d;
    last_page_q  <= last_page_d;
    first_row_q  <= first_row_d;
    last_row_q   <= last_row_d;
    color_q      <= color_d;
    res_rd_q     <= res_rd_d;
    res_off_q    <= res_off_d;
    wr_addr_q    <= wr_addr_d;
    wr_mask_q    <= wr_mask_d;
    read_byte_q  <= read_byte_d;
    off_screen_q <= off_screen_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_byte_o  = read_byte_q;
  assign off_screen_o = off_screen_q;

  a_no_req_with_pending_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && wr_pend_q))
    else $error("request taken while a fill write is still pending");

  a_sweep_excludes_fill: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(wr_pend_q && ((state_q == ST_CLEAR) || (state_q == ST_INIT))))
    else $error("fill write collides with clearing sweep");

  a_fill_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> ((page_q <= last_page_q) && (col_q <= last_col_q)))
    else $error("fill walked past the clipped rectangle");

  a_result_after_finish: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && out_free) |=> out_valid_q)
    else $error("finished request did not produce a result");

endmodule

FILE: hw/rtl/pfbrf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfbrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/sv/page_framebuffer_rect_fill_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_rect_fill_test
// Checks the paged frame store: clear, clipped rectangle fill and erase, and
// byte readback. A shadow copy of the store predicts every result, and the
// responses are compared field by field in order. The sender drives random
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module page_framebuffer_rect_fill_test;
  import pfbrf_pkg::*;

  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned ITEM_COUNT  = 580;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       off_screen;
  } page_result_t;

  class page_store_tracker;
    logic [7:0]   shadow [STORE_BYTES];
    page_result_t due_results [$];
    int unsigned  errors;
    int unsigned  n_clear, n_fill, n_read, n_off, n_spare, n_checked;

    function new();
      foreach (shadow[i]) shadow[i] = 8'h00;
      errors = 0;
      n_clear = 0; n_fill = 0; n_read = 0; n_off = 0; n_spare = 0; n_checked = 0;
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                               logic [7:0] w, logic [7:0] h, logic lit);
      page_result_t res;
      int unsigned  xi, yi, cw, ch, y_end, top, first, last, idx;
      logic [7:0]   mask;
      res = '0;
      xi = x;
      yi = y;
      case (kind)
        KIND_CLEAR: begin
          foreach (shadow[i]) shadow[i] = 8'h00;
          n_clear++;
        end
        KIND_FILL: begin
          n_fill++;
          if (xi >= SCREEN_WIDTH || yi >= SCREEN_HEIGHT) begin
            res.off_screen = 1'b1;
            n_off++;
          end else begin
            cw = w;
            ch = h;
            if (xi + cw > SCREEN_WIDTH) cw = SCREEN_WIDTH - xi;
            if (yi + ch > SCREEN_HEIGHT) ch = SCREEN_HEIGHT - yi;
            if (cw != 0 && ch != 0) begin
              y_end = yi + ch;
              for (int unsigned pg = yi / PAGE_ROWS; pg <= (y_end - 1) / PAGE_ROWS; pg++) begin
                top   = pg * PAGE_ROWS;
                first = (yi > top) ? yi - top : 0;
                last  = (y_end - 1 < top + 7) ? y_end - 1 - top : 7;
                mask  = (8'hFF << first) & (8'hFF >> (7 - last));
                for (int unsigned col = xi; col < xi + cw; col++) begin
                  idx = pg * SCREEN_WIDTH + col;
                  if (lit) shadow[idx] = shadow[idx] | mask;
                  else     shadow[idx] = shadow[idx] & ~mask;
                end
              end
            end
          end
        end
        KIND_READ: begin
          n_read++;
          if (xi >= SCREEN_WIDTH || yi >= SCREEN_HEIGHT) begin
            res.off_screen = 1'b1;
            n_off++;
          end else begin
            res.read_byte = shadow[(yi / PAGE_ROWS) * SCREEN_WIDTH + xi];
          end
        end
        default: n_spare++;
      endcase
      due_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] read_byte, logic off_screen);
      page_result_t exp;
      if (due_results.size() == 0) begin
        $error("result with no request pending: read_byte %0h off_screen %0b",
               read_byte, off_screen);
        errors++;
      end else begin
        exp = due_results.pop_front();
        n_checked++;
        if (read_byte !== exp.read_byte) begin
          $error("read_byte: expected %0h, got %0h", exp.read_byte, read_byte);
          errors++;
        end
        if (off_screen !== exp.off_screen) begin
          $error("off_screen: expected %0b, got %0b", exp.off_screen, off_screen);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i        = KIND_CLEAR;
  logic [7:0] x_pos_i       = 8'h00;
  logic [7:0] y_pos_i       = 8'h00;
  logic [7:0] rect_width_i  = 8'h00;
  logic [7:0] rect_height_i = 8'h00;
  logic       color_i       = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] read_byte_o;
  logic       off_screen_o;

  page_store_tracker tracker;

  int unsigned stall_left = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_cycles  = 0;

  page_framebuffer_rect_fill dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_byte_o   (read_byte_o),
    .off_screen_o  (off_screen_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      case (rx_mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = 1'($urandom_range(0, 1));
        default: begin
          out_ready_i = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
        end
      endcase
    end
    rx_cycles++;
    if (rx_cycles % 300 == 0) rx_mode = $urandom_range(0, 2);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(read_byte_o, off_screen_o);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("page_framebuffer_rect_fill_test NOT OK");
    $finish;
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                              logic [7:0] w, logic [7:0] h, logic lit);
    kind_i        = kind;
    x_pos_i       = x;
    y_pos_i       = y;
    rect_width_i  = w;
    rect_height_i = h;
    color_i       = lit;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(kind, x, y, w, h, lit);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent, burst, gap, r, r2;
    logic [1:0]  k;
    logic [7:0]  rx, ry, rw, rh;
    logic        rc;
    logic [7:0]  last_x, last_y, last_w, last_h;

    tracker = new();
    last_x = 8'd0; last_y = 8'd0; last_w = 8'd8; last_h = 8'd8;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(KIND_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
    send_request(KIND_READ, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0);
    send_request(KIND_FILL, 8'd5, 8'd3, 8'd1, 8'd1, 1'b0);
    send_request(KIND_READ, 8'd5, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(KIND_FILL, 8'd0, 8'd10, 8'd128, 8'd1, 1'b0);
    send_request(KIND_FILL, 8'd100, 8'd0, 8'd1, 8'd64, 1'b0);
    send_request(KIND_READ, 8'd100, 8'd40, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd60, 8'd13, 8'd0, 8'd0, 1'b0);
    send_request(KIND_FILL, 8'd128, 8'd0, 8'd4, 8'd4, 1'b1);
    send_request(KIND_FILL, 8'd0, 8'd64, 8'd4, 8'd4, 1'b1);
    send_request(KIND_FILL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_request(KIND_FILL, 8'd3, 8'd3, 8'd0, 8'd5, 1'b0);
    send_request(KIND_FILL, 8'd3, 8'd3, 8'd5, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd0, 8'd200, 8'd0, 8'd0, 1'b0);
    send_request(KIND_SPARE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_request(KIND_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd64, 8'd32, 8'd0, 8'd0, 1'b0);
    send_request(KIND_FILL, 8'd10, 8'd5, 8'd20, 8'd13, 1'b1);
    send_request(KIND_READ, 8'd15, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd15, 8'd8, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd29, 8'd17, 8'd0, 8'd0, 1'b0);
    send_request(KIND_FILL, 8'd120, 8'd60, 8'd255, 8'd255, 1'b1);
    send_request(KIND_READ, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0);
    drain_results();
    @(negedge clk_i);

    sent = 0;
    while (sent < ITEM_COUNT) begin
      burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && sent < ITEM_COUNT; b++) begin
        r  = $urandom_range(0, 99);
        k  = KIND_READ;
        rx = 8'($urandom);
        ry = 8'($urandom);
        rw = 8'($urandom);
        rh = 8'($urandom);
        rc = 1'($urandom);
        if (r < 3) begin
          k = KIND_CLEAR;
        end else if (r < 5) begin
          k = KIND_SPARE;
        end else if (r < 50) begin
          k  = KIND_FILL;
          rx = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
          ry = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 63));
          r2 = $urandom_range(0, 99);
          rw = (r2 < 85) ? 8'($urandom_range(0, 12)) :
               (r2 < 95) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
          r2 = $urandom_range(0, 99);
          rh = (r2 < 85) ? 8'($urandom_range(0, 20)) :
               (r2 < 95) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
          rc = ($urandom_range(0, 99) < 70);
          last_x = rx; last_y = ry; last_w = rw; last_h = rh;
        end else begin
          r2 = $urandom_range(0, 99);
          if (r2 < 60) begin
            rx = last_x + 8'($urandom_range(0, last_w));
            ry = last_y + 8'($urandom_range(0, last_h));
          end else if (r2 < 90) begin
            rx = 8'($urandom_range(0, 127));
            ry = 8'($urandom_range(0, 63));
          end
        end
        send_request(k, rx, ry, rw, rh, rc);
        sent++;
        if (sent == ITEM_COUNT / 2) drain_results();
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i = 1'b0;

    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("checked %0d results: %0d clears, %0d fills, %0d reads, %0d spare kinds",
             tracker.n_checked, tracker.n_clear, tracker.n_fill, tracker.n_read,
             tracker.n_spare);
    $display("%0d requests fell off screen; %0d mismatches seen", tracker.n_off,
             tracker.errors);
    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("page_framebuffer_rect_fill_test OK");
    end else begin
      $display("page_framebuffer_rect_fill_test NOT OK");
    end
    $finish;
  end

endmodule
